>>> src/smss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted multiset store package
// Shared types, codes and defaults for the sorted multiset store and its
// cell chain.
// ----------------------------------------------------------------------------
package smss_pkg;

	// Default number of entries held by the store.
	localparam int CAPACITY_DEF = 32;

	// Stored value type.
	typedef logic signed [31:0] value_t;

	// Operation codes carried by an input beat.
	typedef enum logic [1:0] {
		OP_INSERT      = 2'd0,
		OP_REMOVE_ONE  = 2'd1,
		OP_COUNT       = 2'd2,
		OP_REMOVE_UPTO = 2'd3
	} op_t;

	// Status codes carried by a result beat.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_NEG_LIMIT = 2'd3
	} status_t;

	// What every cell of the chain does in the current cycle.
	typedef enum logic [1:0] {
		CM_HOLD,
		CM_INSERT,
		CM_REMOVE
	} cell_mode_t;

	// Control broadcast from the sequencer to all cells.
	typedef struct packed {
		cell_mode_t mode;
		value_t     key;
		logic       desc;
	} cell_ctrl_t;

endpackage

>>> src/smss_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted multiset store channels
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------

// Request channel: one operation per beat.
interface smss_req_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  operation;
	logic signed [31:0] value;
	logic signed [15:0] count_limit;

	modport source (output valid, output operation, output value, output count_limit,
		input ready);
	modport sink (input valid, input operation, input value, input count_limit,
		output ready);
endinterface

// Result channel: one result per request.
interface smss_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [5:0] match_count;
	logic [5:0] stored_size;
	logic       is_empty;

	modport source (output valid, output status, output match_count, output stored_size,
		output is_empty, input ready);
	modport sink (input valid, input status, input match_count, input stored_size,
		input is_empty, output ready);
endinterface

>>> src/smss_prefix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted multiset store prefix OR
// Log-depth inclusive prefix OR across the cell chain; bit i is set when any
// flag at position i or below is set.
// ----------------------------------------------------------------------------
module smss_prefix #(
	parameter int WIDTH = smss_pkg::CAPACITY_DEF
) (
	input  logic [WIDTH-1:0] flags,
	output logic [WIDTH-1:0] incl
);
	localparam int LVLS = $clog2(WIDTH);

	logic [WIDTH-1:0] lvl [LVLS+1];

	// Each level folds in the result from a doubling distance below.
	always_comb begin
		lvl[0] = flags;
		for (int l = 0; l < LVLS; l++) begin
			lvl[l+1] = lvl[l] | (lvl[l] << (1 << l));
		end
	end

	assign incl = lvl[LVLS];

endmodule

>>> src/smss_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted multiset store cell
// Holds one entry, compares it with the broadcast key and either keeps it,
// takes the key, or takes a neighbor's entry during a shift.
// ----------------------------------------------------------------------------
module smss_cell (
	input  logic                 clk,
	input  smss_pkg::cell_ctrl_t ctrl,
	input  logic                 occupied,
	input  smss_pkg::value_t     left_entry,
	input  smss_pkg::value_t     right_entry,
	input  logic                 shift_excl,
	input  logic                 shift_incl,
	output smss_pkg::value_t     entry,
	output logic                 stop,
	output logic                 hit
);
	import smss_pkg::*;

	value_t entry_q;
	value_t entry_nxt;
	logic   ahead_or_equal;

	// Compare the held entry with the key in the selected order.
	always_comb begin
		if (ctrl.desc) begin
			ahead_or_equal = (entry_q >= ctrl.key);
		end else begin
			ahead_or_equal = (entry_q <= ctrl.key);
		end
		// An empty cell always marks the insert point.
		stop = !occupied || !ahead_or_equal;
		hit  = occupied && (entry_q == ctrl.key);
	end

	// Select the new content of the cell.
	always_comb begin
		entry_nxt = entry_q;
		case (ctrl.mode)
			CM_INSERT: begin
				if (shift_excl) begin
					entry_nxt = left_entry;
				end else if (stop) begin
					entry_nxt = ctrl.key;
				end
			end
			CM_REMOVE: begin
				if (shift_incl) begin
					entry_nxt = right_entry;
				end
			end
			default: begin
				entry_nxt = entry_q;
			end
		endcase
	end

	// Entry storage; content is meaningful only below the fill count.
	always_ff @(posedge clk) begin
		if (ctrl.mode != CM_HOLD) begin
			entry_q <= entry_nxt;
		end
	end

	assign entry = entry_q;

endmodule

>>> src/sorted_multiset_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted multiset store
// Bounded multiset of signed 32-bit values kept in order in a chain of cells,
// with insert, remove one, count and remove up to a limit.
// ----------------------------------------------------------------------------
//  Port       Dir     Contents
//  req        sink    operation, value, count_limit
//  rsp        source  status, match_count, stored_size, is_empty
//  cfg_we     in      write strobe for descending_order
//  cfg_wdata  in      new descending_order value
//
//  Insert, remove one and a negative-limit remove accept the beat in S_IDLE,
//  then compare in S_EXEC, where all cells shift by one position if needed.
//  Count then moves to S_COUNT, as the match vector is registered before the
//  adder tree. Remove up to a limit stays in S_EXEC while the chain shifts out
//  one occurrence per cycle, until the limit is reached or no match is left.
//  Reset empties the store at once. A stalled result holds the final cycle.
// ----------------------------------------------------------------------------
module sorted_multiset_store #(
	parameter int CAPACITY = smss_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	smss_req_if.sink    req,
	smss_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic        cfg_wdata
);
	import smss_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int LVLS  = $clog2(CAPACITY);
	localparam int NP    = 1 << LVLS;

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_COUNT} state_t;

	state_t             state_q;
	logic               desc_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   matched_q;
	op_t                op_q;
	value_t             key_q;
	logic [15:0]        limit_q;
	logic [CAPACITY-1:0] hit_s1;

	logic               rsp_valid_q;
	status_t            rsp_status_q;
	logic [5:0]         rsp_match_q;
	logic [5:0]         rsp_size_q;
	logic               rsp_empty_q;

	// Cell chain signals.
	cell_ctrl_t          ctrl;
	value_t              entry [CAPACITY];
	logic [CAPACITY-1:0] stop_v;
	logic [CAPACITY-1:0] hit_v;
	logic [CAPACITY-1:0] occ_v;
	logic [CAPACITY-1:0] flags_v;
	logic [CAPACITY-1:0] incl_v;
	logic [CAPACITY-1:0] excl_v;

	// Sequencer decisions.
	logic               out_free;
	logic               full;
	logic               any_hit;
	logic               more;
	logic               finish;
	logic               do_finish;
	cell_mode_t         mode;
	status_t            res_status;
	logic [CNT_W-1:0]   res_match;
	logic [CNT_W-1:0]   res_count;
	logic [NP-1:0]      hit_pad;
	logic [CNT_W-1:0]   pc [LVLS+1][NP];

	// Row of cells; each sees its neighbors' entries for one-step shifts.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		value_t left_entry;
		value_t right_entry;

		if (i == 0) begin : g_first
			assign left_entry = key_q;
		end else begin : g_mid_l
			assign left_entry = entry[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_entry = entry[i];
		end else begin : g_mid_r
			assign right_entry = entry[i+1];
		end

		assign occ_v[i] = (CNT_W'(i) < count_q);

		smss_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (occ_v[i]),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.shift_excl  (excl_v[i]),
			.shift_incl  (incl_v[i]),
			.entry       (entry[i]),
			.stop        (stop_v[i]),
			.hit         (hit_v[i])
		);
	end

	// Insert looks for the first stop point, removals for the first match.
	assign flags_v = (op_q == OP_INSERT) ? stop_v : hit_v;
	assign excl_v  = {incl_v[CAPACITY-2:0], 1'b0};

	smss_prefix #(
		.WIDTH (CAPACITY)
	) u_prefix (
		.flags (flags_v),
		.incl  (incl_v)
	);

	// Registered match vector summed by a balanced adder tree.
	assign hit_pad = NP'(hit_s1);

	always_comb begin
		for (int l = 0; l <= LVLS; l++) begin
			for (int j = 0; j < NP; j++) begin
				pc[l][j] = '0;
			end
		end
		for (int j = 0; j < NP; j++) begin
			pc[0][j] = CNT_W'(hit_pad[j]);
		end
		for (int l = 1; l <= LVLS; l++) begin
			for (int j = 0; j < NP; j++) begin
				if (j < (NP >> l)) begin
					pc[l][j] = pc[l-1][2*j] + pc[l-1][2*j+1];
				end
			end
		end
	end

	assign out_free = !rsp_valid_q || rsp.ready;
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign any_hit  = |hit_v;
	assign more     = any_hit && (16'(matched_q) < limit_q);

	// Per-cycle operation control.
	always_comb begin
		mode       = CM_HOLD;
		finish     = 1'b0;
		res_status = ST_OK;
		res_match  = '0;
		res_count  = count_q;
		case (state_q)
			S_EXEC: begin
				unique case (op_q)
					OP_INSERT: begin
						finish = 1'b1;
						if (full) begin
							res_status = ST_FULL;
						end else begin
							res_count = CNT_W'(count_q + 1'b1);
							if (out_free) begin
								mode = CM_INSERT;
							end
						end
					end
					OP_REMOVE_ONE: begin
						finish = 1'b1;
						if (!any_hit) begin
							res_status = ST_NOT_FOUND;
						end else begin
							res_count = CNT_W'(count_q - 1'b1);
							res_match = CNT_W'(1);
							if (out_free) begin
								mode = CM_REMOVE;
							end
						end
					end
					OP_COUNT: begin
						finish = 1'b0;
					end
					OP_REMOVE_UPTO: begin
						if (limit_q[15]) begin
							finish     = 1'b1;
							res_status = ST_NEG_LIMIT;
						end else if (more) begin
							// Shift out one occurrence, then look again.
							mode = CM_REMOVE;
						end else begin
							finish    = 1'b1;
							res_match = matched_q;
						end
					end
				endcase
			end
			S_COUNT: begin
				finish     = 1'b1;
				res_match  = pc[LVLS][0];
				res_status = (pc[LVLS][0] != '0) ? ST_OK : ST_NOT_FOUND;
			end
			default: begin
				finish = 1'b0;
			end
		endcase
	end

	assign do_finish = finish && out_free;

	assign ctrl.mode = mode;
	assign ctrl.key  = key_q;
	assign ctrl.desc = desc_q;

	// Sequencer state, fill count, order register and result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			desc_q       <= 1'b0;
			count_q      <= '0;
			matched_q    <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= ST_OK;
			rsp_match_q  <= '0;
			rsp_size_q   <= '0;
			rsp_empty_q  <= 1'b1;
		end else begin
			if (cfg_we) begin
				desc_q <= cfg_wdata;
			end

			if (mode == CM_INSERT) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (mode == CM_REMOVE) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						matched_q <= '0;
						state_q   <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (op_q == OP_COUNT) begin
						state_q <= S_COUNT;
					end else if (do_finish) begin
						state_q <= S_IDLE;
					end else if (mode == CM_REMOVE) begin
						matched_q <= CNT_W'(matched_q + 1'b1);
					end
				end
				S_COUNT: begin
					if (do_finish) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (do_finish) begin
				rsp_valid_q  <= 1'b1;
				rsp_status_q <= res_status;
				rsp_match_q  <= 6'(res_match);
				rsp_size_q   <= 6'(res_count);
				rsp_empty_q  <= (res_count == '0);
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request fields and the count snapshot.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			op_q    <= op_t'(req.operation);
			key_q   <= req.value;
			limit_q <= req.count_limit;
		end
		if (state_q == S_EXEC && op_q == OP_COUNT) begin
			hit_s1 <= hit_v;
		end
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.match_count = rsp_match_q;
	assign rsp.stored_size = rsp_size_q;
	assign rsp.is_empty    = rsp_empty_q;

`ifndef NO_ASSERTIONS
	// The fill count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("fill count above capacity");

	// An insert shift never runs on a full store.
	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		(mode == CM_INSERT) |-> !full)
		else $error("insert shift on a full store");

	// A remove shift always has a matching occupied entry.
	a_remove_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(mode == CM_REMOVE) |-> (any_hit && count_q != '0))
		else $error("remove shift without a match");

	// An accepted beat always starts the compare cycle.
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == S_EXEC))
		else $error("accepted beat did not enter execution");

	// A result is loaded only into a free output slot.
	a_result_slot: assert property (@(posedge clk) disable iff (!arst_n)
		do_finish |-> (!rsp_valid_q || rsp.ready))
		else $error("result overwrote a pending beat");
`endif

endmodule

>>> tb/tb_sorted_multiset_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted multiset store testbench
// Drives insert, remove one, count and remove-up-to beats into the store and
// checks every result beat against a shadow copy of the sorted contents kept
// in the testbench. Runs a directed opening, then random phases in both sort
// orders with sender gaps, receiver stalls and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_sorted_multiset_store;
	import smss_pkg::*;

	localparam int STORE_CAP = CAPACITY_DEF;
	localparam int SETTLE_CYCLES = 40;
	localparam value_t VAL_MIN = 32'h8000_0000;
	localparam value_t VAL_MAX = 32'h7fff_ffff;

	typedef logic signed [15:0] limit_t;

	typedef struct packed {
		status_t    status;
		logic [5:0] match_count;
		logic [5:0] stored_size;
		logic       is_empty;
	} smss_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	smss_req_if req_ch();
	smss_rsp_if rsp_ch();

	// Shadow copy of the store and its order setting.
	value_t       shadow_vals[STORE_CAP];
	int           shadow_len = 0;
	bit           desc_mode = 1'b0;
	value_t       value_pool[8];
	smss_result_t pending_results[$];

	int mismatches = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int hold_request = 0;

	sorted_multiset_store #(
		.CAPACITY(STORE_CAP)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the store hangs.
	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

	// True when a may stand at or ahead of b in the current sort order.
	function automatic bit sits_ahead(value_t a, value_t b);
		return desc_mode ? (a >= b) : (a <= b);
	endfunction

	// Apply one operation to the shadow store and return the expected result.
	function automatic smss_result_t perform_op(op_t op, value_t v, limit_t lim);
		smss_result_t r;
		int pos;
		int wr;
		int i;
		int hits;
		r.status = ST_OK;
		hits = 0;
		case (op)
			OP_INSERT: begin
				if (shadow_len >= STORE_CAP) begin
					r.status = ST_FULL;
				end else begin
					pos = 0;
					while (pos < shadow_len && sits_ahead(shadow_vals[pos], v))
						pos++;
					for (i = shadow_len; i > pos; i--)
						shadow_vals[i] = shadow_vals[i - 1];
					shadow_vals[pos] = v;
					shadow_len++;
				end
			end
			OP_REMOVE_ONE: begin
				pos = 0;
				while (pos < shadow_len && shadow_vals[pos] != v)
					pos++;
				if (pos == shadow_len) begin
					r.status = ST_NOT_FOUND;
				end else begin
					for (i = pos; i + 1 < shadow_len; i++)
						shadow_vals[i] = shadow_vals[i + 1];
					shadow_len--;
					hits = 1;
				end
			end
			OP_COUNT: begin
				for (i = 0; i < shadow_len; i++)
					if (shadow_vals[i] == v)
						hits++;
				r.status = (hits != 0) ? ST_OK : ST_NOT_FOUND;
			end
			OP_REMOVE_UPTO: begin
				if (lim < 0) begin
					r.status = ST_NEG_LIMIT;
				end else begin
					// Compact the survivors toward the front.
					wr = 0;
					for (i = 0; i < shadow_len; i++) begin
						if (shadow_vals[i] == v && hits < int'(lim)) begin
							hits++;
						end else begin
							shadow_vals[wr] = shadow_vals[i];
							wr++;
						end
					end
					shadow_len = wr;
				end
			end
		endcase
		r.match_count = 6'(hits);
		r.stored_size = 6'(shadow_len);
		r.is_empty = (shadow_len == 0);
		return r;
	endfunction

	// Offer one request beat, with random gaps ahead of it, and record the
	// expected result once the beat is taken.
	task automatic send_req(input op_t op, input value_t v, input limit_t lim);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.value <= v;
		req_ch.count_limit <= lim;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_results.push_back(perform_op(op, v, lim));
	endtask

	// Stop offering and wait until every expected result has come back.
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the order register; only called while the store is idle.
	task automatic write_order(input bit d);
		cfg_we <= 1'b1;
		cfg_wdata <= d;
		@(posedge clk);
		desc_mode = d;
		cfg_we <= 1'b0;
	endtask

	// Values: often already stored or from a small pool, so that duplicates
	// are common; otherwise fully random.
	function automatic value_t pick_value();
		int sel;
		sel = $urandom_range(99);
		if (sel < 30 && shadow_len > 0)
			return shadow_vals[$urandom_range(shadow_len - 1)];
		if (sel < 65)
			return value_pool[$urandom_range(7)];
		return value_t'($urandom);
	endfunction

	// Limits: mostly small, with negatives, large values and both extremes.
	function automatic limit_t pick_limit();
		int sel;
		sel = $urandom_range(99);
		if (sel < 50)
			return limit_t'($urandom_range(3));
		if (sel < 65)
			return limit_t'($urandom_range(40, 4));
		if (sel < 77)
			return limit_t'($urandom) | 16'h8000;
		if (sel < 92)
			return limit_t'($urandom);
		return (sel < 96) ? 16'h8000 : 16'h7fff;
	endfunction

	// Random beats in alternating stretches that fill and then drain the store.
	task automatic run_random(input int n);
		int k;
		int ins_pct;
		op_t op;
		for (k = 0; k < n; k++) begin
			ins_pct = ((k / 60) % 2 == 0) ? 65 : 25;
			if ($urandom_range(99) < ins_pct)
				op = OP_INSERT;
			else
				op = op_t'($urandom_range(3, 1));
			send_req(op, pick_value(), pick_limit());
		end
	endtask

	// Edge values, every operation and each status but full on a small store.
	task automatic test_directed();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		write_order(1'b0);
		send_req(OP_COUNT, 5, 0);
		send_req(OP_REMOVE_ONE, 5, 0);
		send_req(OP_REMOVE_UPTO, 5, 0);
		send_req(OP_REMOVE_UPTO, 5, -1);
		send_req(OP_INSERT, VAL_MAX, 0);
		send_req(OP_INSERT, VAL_MIN, 0);
		send_req(OP_INSERT, 0, 0);
		send_req(OP_INSERT, 0, 0);
		send_req(OP_INSERT, -1, 0);
		send_req(OP_INSERT, VAL_MIN, 0);
		send_req(OP_COUNT, 0, 0);
		send_req(OP_COUNT, VAL_MIN, 0);
		send_req(OP_REMOVE_UPTO, 0, 16'h8000);
		send_req(OP_REMOVE_UPTO, VAL_MIN, 1);
		send_req(OP_REMOVE_UPTO, 0, 16'h7fff);
		send_req(OP_REMOVE_ONE, VAL_MAX, 0);
		send_req(OP_REMOVE_ONE, VAL_MAX, 0);
		drain_results();
		// Flip the order while entries are still held.
		write_order(1'b1);
		send_req(OP_INSERT, 32'h5555_5555, 0);
		send_req(OP_INSERT, 32'haaaa_aaaa, 0);
		send_req(OP_INSERT, 7, 0);
		send_req(OP_REMOVE_UPTO, 7, 0);
		send_req(OP_REMOVE_ONE, 32'haaaa_aaaa, 0);
		send_req(OP_REMOVE_UPTO, VAL_MIN, 5);
		drain_results();
	endtask

	// Back-to-back beats in ascending order.
	task automatic test_steady_ascending();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		write_order(1'b0);
		run_random(190);
		drain_results();
	endtask

	// Descending order over whatever the store holds, sender mostly idle.
	task automatic test_descending_sparse_sender();
		src_idle_pct = 85;
		sink_stall_pct = 0;
		write_order(1'b1);
		run_random(190);
		drain_results();
	endtask

	// Ascending again, receiver stalling most cycles.
	task automatic test_receiver_stalls();
		src_idle_pct = 0;
		sink_stall_pct = 85;
		write_order(1'b0);
		run_random(190);
		drain_results();
	endtask

	// Descending, light idling on both sides.
	task automatic test_both_sides_idle();
		src_idle_pct = 18;
		sink_stall_pct = 18;
		write_order(1'b1);
		run_random(190);
		drain_results();
	endtask

	// Long receiver hold-off while inserts keep coming: the block must stall
	// its input, and the store reaches full.
	task automatic test_backpressure_fill();
		int k;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_request = 400;
		for (k = 0; k < 40; k++)
			send_req(OP_INSERT, pick_value(), pick_limit());
		for (k = 0; k < 10; k++)
			send_req(op_t'($urandom_range(3, 1)), pick_value(), pick_limit());
		drain_results();
	endtask

	// Receiver ready: random stalls plus an occasional long hold-off.
	initial begin : ready_drive
		int hold_left;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	task automatic report_field(input string field, input int unsigned want,
		input int unsigned got);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		mismatches++;
	endtask

	// Compare each result beat with the oldest expectation.
	always @(posedge clk) begin
		smss_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected beat, status %0d count %0d size %0d empty %0d",
					$time, rsp_ch.status, rsp_ch.match_count, rsp_ch.stored_size,
					rsp_ch.is_empty);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.status !== want.status)
					report_field("status", want.status, rsp_ch.status);
				if (rsp_ch.match_count !== want.match_count)
					report_field("match_count", want.match_count, rsp_ch.match_count);
				if (rsp_ch.stored_size !== want.stored_size)
					report_field("stored_size", want.stored_size, rsp_ch.stored_size);
				if (rsp_ch.is_empty !== want.is_empty)
					report_field("is_empty", want.is_empty, rsp_ch.is_empty);
			end
		end
	end

	// Reset, then run the tests in turn.
	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.operation <= OP_INSERT;
		req_ch.value <= '0;
		req_ch.count_limit <= '0;
		value_pool[0] = VAL_MIN;
		value_pool[1] = VAL_MAX;
		value_pool[2] = 0;
		value_pool[3] = -1;
		for (int p = 4; p < 8; p++)
			value_pool[p] = value_t'($urandom);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_steady_ascending();
		test_backpressure_fill();
		test_descending_sparse_sender();
		test_receiver_stalls();
		test_both_sides_idle();

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
